>>> rtl/ofdm_frame_prefix_gate_macros.svh
// Assertion macros used by the port-level checker of the prefix gate.
`ifndef OFDM_FRAME_PREFIX_GATE_MACROS_SVH
`define OFDM_FRAME_PREFIX_GATE_MACROS_SVH

// Same-cycle implication, sampled on clk and quiet while arst_n is low.
`define OFPG_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("prefix gate check failed: same-cycle implication");

// Next-cycle implication, sampled on clk and quiet while arst_n is low.
`define OFPG_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("prefix gate check failed: next-cycle implication");

`endif

>>> rtl/ofdmpg_pkg.sv
// Package with the phase encoding, register indexes and configuration type of the prefix gate.
`timescale 1ns / 1ps

package ofdmpg_pkg;

	localparam int FFT_W    = 13;
	localparam int PREFIX_W = 11;
	localparam int DELAY_W  = 20;
	localparam int SYM_W    = 10;
	localparam int SPAN_W   = 14;
	localparam int CFG_DATA_W = 20;
	localparam int CFG_ADDR_W = 2;

	localparam logic [CFG_ADDR_W-1:0] REG_FFT_SIZE          = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_PREFIX_LEN        = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_START_DELAY       = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_SYMBOLS_PER_FRAME = 2'd3;

	localparam logic [FFT_W-1:0]    FFT_SIZE_RST    = 13'd64;
	localparam logic [PREFIX_W-1:0] PREFIX_LEN_RST  = 11'd16;
	localparam logic [DELAY_W-1:0]  START_DELAY_RST = 20'd0;
	localparam logic [SYM_W-1:0]    SYMBOLS_RST     = 10'd1;

	typedef enum logic [6:0] {
		PH_WAIT         = 7'b0000001,
		PH_SHORT_PREFIX = 7'b0000010,
		PH_SHORT_BODY   = 7'b0000100,
		PH_LONG_PREFIX  = 7'b0001000,
		PH_LONG_BODY    = 7'b0010000,
		PH_DATA_PREFIX  = 7'b0100000,
		PH_PASS         = 7'b1000000
	} phase_t;

	typedef struct packed {
		logic [FFT_W-1:0]    fft_size;
		logic [PREFIX_W-1:0] prefix_len;
		logic [DELAY_W-1:0]  start_delay;
		logic [SYM_W-1:0]    symbols_per_frame;
	} cfg_t;

endpackage

>>> rtl/ofdm_frame_prefix_gate.sv
// Top level of the OFDM frame prefix gate: stream ports, configuration registers, item pipeline.
`timescale 1ns / 1ps

// Channel    Direction  Signals                                   Content
// s_axis     in         s_axis_tvalid/tready/tdata                one complex sample
// m_axis     out        m_axis_tvalid/tready/tdata                one passed symbol sample
// cfg        in         cfg_we, cfg_index, cfg_wdata              register writes
//
// The gate takes one item per clock cycle when the output side keeps up.
// An accepted item waits in the input register, where the sequencer decides
// whether it passes; a passed item shows on m_axis in the cycle after it moves on.
// Reset clears the valid flags and the sequencer and loads the register defaults.
// A stalled m_axis holds its item; s_axis_tready drops only while an item that
// must pass waits behind that stalled output.

module ofdm_frame_prefix_gate #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COUNT_WIDTH  = 21
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// Fields from bit 0 up: in_re, in_im, zero fill to whole bytes.
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// Fields from bit 0 up: out_re, out_im, zero fill to whole bytes.
	output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
	input  logic                                cfg_we,
	input  logic [ofdmpg_pkg::CFG_ADDR_W-1:0]   cfg_index,
	input  logic [ofdmpg_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

	localparam int PAIR_W = 2 * SAMPLE_WIDTH;
	localparam int DATA_W = ((PAIR_W + 7) / 8) * 8;

	ofdmpg_pkg::cfg_t     cfg_q;
	logic                 valid_s1;
	logic [PAIR_W-1:0]    data_s1;
	logic                 out_valid_q;
	logic [PAIR_W-1:0]    out_data_q;
	logic                 emit, out_free, advance;

	// Configuration registers; the user writes only while the gate is idle, not enforced here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fft_size          <= ofdmpg_pkg::FFT_SIZE_RST;
			cfg_q.prefix_len        <= ofdmpg_pkg::PREFIX_LEN_RST;
			cfg_q.start_delay       <= ofdmpg_pkg::START_DELAY_RST;
			cfg_q.symbols_per_frame <= ofdmpg_pkg::SYMBOLS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				ofdmpg_pkg::REG_FFT_SIZE:
					cfg_q.fft_size <= cfg_wdata[ofdmpg_pkg::FFT_W-1:0];
				ofdmpg_pkg::REG_PREFIX_LEN:
					cfg_q.prefix_len <= cfg_wdata[ofdmpg_pkg::PREFIX_W-1:0];
				ofdmpg_pkg::REG_START_DELAY:
					cfg_q.start_delay <= cfg_wdata[ofdmpg_pkg::DELAY_W-1:0];
				ofdmpg_pkg::REG_SYMBOLS_PER_FRAME:
					cfg_q.symbols_per_frame <= cfg_wdata[ofdmpg_pkg::SYM_W-1:0];
				default: ;
			endcase
		end
	end

	// The item in the input register moves on when it is dropped, or when it
	// passes and the output register is free or is being emptied this cycle.
	assign out_free      = !out_valid_q || m_axis_tready;
	assign advance       = valid_s1 && (!emit || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			data_s1 <= s_axis_tdata[PAIR_W-1:0];
		end
	end

	ofdmpg_seq #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.step   (advance),
		.emit   (emit)
	);

	// Output register: loaded with the sample of a passing item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_data_q <= data_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = DATA_W'(out_data_q);

endmodule

>>> rtl/ofdmpg_seq.sv
// Frame sequencer of the prefix gate: phase, sample counter and symbol counter.
`timescale 1ns / 1ps

module ofdmpg_seq #(
	parameter int COUNT_WIDTH = 21
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ofdmpg_pkg::cfg_t  cfg,
	input  logic              step,
	output logic              emit
);

	localparam int CMP_W = (COUNT_WIDTH > ofdmpg_pkg::DELAY_W) ?
		COUNT_WIDTH : ofdmpg_pkg::DELAY_W;

	ofdmpg_pkg::phase_t               phase_q, phase_d;
	logic [COUNT_WIDTH-1:0]           cnt_q, cnt_d, cnt_inc;
	logic [ofdmpg_pkg::SYM_W-1:0]     sym_q, sym_d, sym_inc;
	logic [ofdmpg_pkg::SPAN_W-1:0]    span;
	logic [CMP_W-1:0]                 cnt_x;
	logic                             body_done, prefix_hit, delay_done;

	assign cnt_inc    = cnt_q + COUNT_WIDTH'(1);
	assign sym_inc    = sym_q + ofdmpg_pkg::SYM_W'(1);
	assign span       = ofdmpg_pkg::SPAN_W'(cfg.fft_size) + ofdmpg_pkg::SPAN_W'(cfg.prefix_len);
	assign cnt_x      = CMP_W'(cnt_inc);
	assign body_done  = cnt_x >= CMP_W'(span);
	assign prefix_hit = cnt_x == CMP_W'(cfg.prefix_len);
	assign delay_done = cnt_x > CMP_W'(cfg.start_delay);
	assign emit       = (phase_q == ofdmpg_pkg::PH_PASS);

	always_comb begin
		phase_d = phase_q;
		cnt_d   = cnt_inc;
		sym_d   = sym_q;
		case (phase_q)
			ofdmpg_pkg::PH_WAIT: begin
				if (delay_done) begin
					cnt_d   = COUNT_WIDTH'(1);
					phase_d = ofdmpg_pkg::PH_SHORT_PREFIX;
				end
			end
			ofdmpg_pkg::PH_SHORT_PREFIX: begin
				if (prefix_hit) phase_d = ofdmpg_pkg::PH_SHORT_BODY;
			end
			ofdmpg_pkg::PH_LONG_PREFIX: begin
				if (prefix_hit) phase_d = ofdmpg_pkg::PH_LONG_BODY;
			end
			ofdmpg_pkg::PH_DATA_PREFIX: begin
				if (prefix_hit) phase_d = ofdmpg_pkg::PH_PASS;
			end
			ofdmpg_pkg::PH_SHORT_BODY: begin
				if (body_done) begin
					phase_d = ofdmpg_pkg::PH_LONG_PREFIX;
					cnt_d   = '0;
				end
			end
			ofdmpg_pkg::PH_LONG_BODY: begin
				if (body_done) begin
					phase_d = ofdmpg_pkg::PH_DATA_PREFIX;
					cnt_d   = '0;
				end
			end
			ofdmpg_pkg::PH_PASS: begin
				if (body_done) begin
					cnt_d = '0;
					if (sym_inc == cfg.symbols_per_frame) begin
						sym_d   = '0;
						phase_d = ofdmpg_pkg::PH_SHORT_PREFIX;
					end else begin
						sym_d   = sym_inc;
						phase_d = ofdmpg_pkg::PH_DATA_PREFIX;
					end
				end
			end
			default: begin
				phase_d = ofdmpg_pkg::PH_WAIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ofdmpg_pkg::PH_WAIT;
			cnt_q   <= '0;
			sym_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			sym_q   <= sym_d;
		end
	end

endmodule

>>> rtl/ofdmpg_chk.sv
// Port-level checker of the prefix gate and its bind to the top level.
`timescale 1ns / 1ps
`include "ofdm_frame_prefix_gate_macros.svh"

module ofdmpg_chk #(
	parameter int SAMPLE_WIDTH = 16
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_axis_tvalid,
	input logic                                s_axis_tready,
	input logic                                m_axis_tvalid,
	input logic                                m_axis_tready,
	input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata
);

	// A stalled output item holds.
	`OFPG_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

	// The input side only backs up behind a stalled output.
	`OFPG_ASSERT_IMPLY(a_in_stall, !s_axis_tready, m_axis_tvalid && !m_axis_tready)

	// A fresh output item went straight through the input and output registers.
	`OFPG_ASSERT_IMPLY(a_out_origin, $rose(m_axis_tvalid), $past(s_axis_tvalid && s_axis_tready, 2))

	// Bits above the two sample fields stay zero on the output.
	`OFPG_ASSERT_IMPLY(a_out_fill, m_axis_tvalid, (m_axis_tdata >> (2*SAMPLE_WIDTH)) == '0)

endmodule

bind ofdm_frame_prefix_gate ofdmpg_chk #(
	.SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

>>> bench/ofdm_frame_prefix_gate_chk.sv
// Checker for the prefix gate: watches all channels, predicts the passed samples and compares them.
`timescale 1ns / 1ps

module ofdm_frame_prefix_gate_chk #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COUNT_WIDTH  = 21
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	input  logic                                s_tready,
	// Fields from bit 0 up: in_re, in_im, zero fill to whole bytes.
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_tdata,
	input  logic                                m_tvalid,
	input  logic                                m_tready,
	// Fields from bit 0 up: out_re, out_im, zero fill to whole bytes.
	input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_tdata,
	input  logic                                cfg_we,
	input  logic [ofdmpg_pkg::CFG_ADDR_W-1:0]   cfg_index,
	input  logic [ofdmpg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output int                                  fail_count,
	output int                                  pending,
	output int                                  checked
);

	import ofdmpg_pkg::*;

	localparam int SW = SAMPLE_WIDTH;

	typedef struct packed {
		logic [SW-1:0] im;
		logic [SW-1:0] re;
	} sample_t;

	// Own copy of the gate's registers and sequencer state.
	logic [FFT_W-1:0]       fft_q;
	logic [PREFIX_W-1:0]    prefix_q;
	logic [DELAY_W-1:0]     delay_q;
	logic [SYM_W-1:0]       spf_q;
	phase_t                 ph;
	logic [COUNT_WIDTH-1:0] smp_cnt;
	logic [SYM_W-1:0]       sym_cnt;

	sample_t passed_q[$];
	int      mismatches;
	int      results;

	// Advances the sequencer by one sample; returns 1 when that sample passes.
	function automatic bit advance_gate();
		int unsigned span;
		bit          passes;
		span = prefix_q + fft_q;
		passes = 1'b0;
		smp_cnt = smp_cnt + 1'b1;
		case (ph)
			PH_WAIT: begin
				if (smp_cnt > delay_q) begin
					smp_cnt = COUNT_WIDTH'(1);
					ph = PH_SHORT_PREFIX;
				end
			end
			PH_SHORT_PREFIX: if (smp_cnt == prefix_q) ph = PH_SHORT_BODY;
			PH_LONG_PREFIX:  if (smp_cnt == prefix_q) ph = PH_LONG_BODY;
			PH_DATA_PREFIX:  if (smp_cnt == prefix_q) ph = PH_PASS;
			PH_SHORT_BODY: begin
				if (smp_cnt >= span) begin
					ph = PH_LONG_PREFIX;
					smp_cnt = '0;
				end
			end
			PH_LONG_BODY: begin
				if (smp_cnt >= span) begin
					ph = PH_DATA_PREFIX;
					smp_cnt = '0;
				end
			end
			PH_PASS: begin
				passes = 1'b1;
				if (smp_cnt >= span) begin
					sym_cnt = sym_cnt + 1'b1;
					if (sym_cnt == spf_q) begin
						ph = PH_SHORT_PREFIX;
						sym_cnt = '0;
					end else begin
						ph = PH_DATA_PREFIX;
					end
					smp_cnt = '0;
				end
			end
			default: ph = PH_WAIT;
		endcase
		return passes;
	endfunction

	task automatic note_mismatch(input string what, input logic [SW-1:0] want,
			input logic [SW-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("chk: %s mismatch at result %0d: expected %h, got %h",
				what, results, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		sample_t want;
		sample_t got;
		if (!arst_n) begin
			fft_q = FFT_SIZE_RST;
			prefix_q = PREFIX_LEN_RST;
			delay_q = START_DELAY_RST;
			spf_q = SYMBOLS_RST;
			ph = PH_WAIT;
			smp_cnt = '0;
			sym_cnt = '0;
			passed_q.delete();
			mismatches = 0;
			results = 0;
			fail_count <= 0;
			pending <= 0;
			checked <= 0;
		end else begin
			// Bits above a register's width are dropped.
			if (cfg_we) begin
				case (cfg_index)
					REG_FFT_SIZE:          fft_q = cfg_wdata[FFT_W-1:0];
					REG_PREFIX_LEN:        prefix_q = cfg_wdata[PREFIX_W-1:0];
					REG_START_DELAY:       delay_q = cfg_wdata[DELAY_W-1:0];
					REG_SYMBOLS_PER_FRAME: spf_q = cfg_wdata[SYM_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				if (advance_gate())
					passed_q.push_back(s_tdata[2*SW-1:0]);
			end
			if (m_tvalid && m_tready) begin
				got = m_tdata[2*SW-1:0];
				results++;
				if (passed_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("chk: result %0d arrived with nothing expected, got %h",
							results, got);
				end else begin
					want = passed_q.pop_front();
					if (got.re !== want.re) note_mismatch("out_re", want.re, got.re);
					if (got.im !== want.im) note_mismatch("out_im", want.im, got.im);
				end
			end
			fail_count <= mismatches;
			pending <= passed_q.size();
			checked <= results;
		end
	end

endmodule

>>> bench/tb.sv
// Testbench top for the OFDM frame prefix gate: clock, reset, stimulus, back-pressure and verdict.
`timescale 1ns / 1ps

// The stimulus is planned in whole frames: from the register values it has written,
// the bench knows how many samples make up a frame, so each later register change
// lands with the gate back at the start of a short preamble prefix. The one exception
// is the mid-symbol change of the FFT size, whose remaining frame length is worked
// out from where the symbol was cut. The checker beside the gate does all prediction.

module tb;

	import ofdmpg_pkg::*;

	localparam int SW = 16;
	localparam int DW = ((2*SW+7)/8)*8;
	// Cycles to wait after the last expected result before touching the registers.
	localparam int SETTLE_CYCLES = 4;

	logic                  clk;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [DW-1:0]         s_axis_tdata;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [DW-1:0]         m_axis_tdata;
	logic                  cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int fail_count;
	int pending;
	int checked;

	// Register values as last written, used only to plan frame lengths.
	int cur_fft;
	int cur_pre;
	int cur_delay;
	int cur_spf;
	bit first_frame;

	int sent;
	int settings;
	int tx_run_left;
	bit tx_idling;

	ofdm_frame_prefix_gate u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	ofdm_frame_prefix_gate_chk u_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked)
	);

	initial clk = 1'b0;
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The longest correct run stays under about 3,000 samples, each with a random gap
	// and a random output stall, plus the long hold-off and the settling between
	// settings: about 0.75 ms. This limit allows roughly four times that.
	initial begin
		#(3_000_000);
		$display("tb: FAIL");
		$finish;
	end

	// One sample part: the corner values turn up often, random bits otherwise.
	function automatic logic [SW-1:0] sample_part();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return SW'($urandom);
		endcase
	endfunction

	// Offers one item after a random gap and returns at the edge that takes it.
	// Gaps come in stretches: mostly on, sometimes off for a run of items.
	task automatic push_sample(input logic [DW-1:0] word);
		int gap;
		if (tx_run_left == 0) begin
			tx_idling = ($urandom_range(0, 3) != 0);
			tx_run_left = $urandom_range(10, 80);
		end
		tx_run_left--;
		gap = tx_idling ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= word;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sent++;
	endtask

	task automatic send_run(input int n);
		repeat (n) push_sample(DW'({sample_part(), sample_part()}));
	endtask

	// Lets every expected sample come out, then waits the settling time for items
	// that pass nothing.
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the caller drops cfg_we after the last one.
	task automatic put_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
	endtask

	// Writes all four registers, with random junk above each width that leaves room for it.
	task automatic apply_cfg(input int f, input int p, input int d, input int s);
		put_reg(REG_FFT_SIZE, CFG_DATA_W'(f) | (CFG_DATA_W'($urandom) << FFT_W));
		put_reg(REG_PREFIX_LEN, CFG_DATA_W'(p) | (CFG_DATA_W'($urandom) << PREFIX_W));
		put_reg(REG_START_DELAY, CFG_DATA_W'(d));
		put_reg(REG_SYMBOLS_PER_FRAME, CFG_DATA_W'(s) | (CFG_DATA_W'($urandom) << SYM_W));
		cfg_we <= 1'b0;
		cur_fft = f;
		cur_pre = p;
		cur_delay = d;
		cur_spf = s;
		settings++;
	endtask

	// Whole frames: two preambles and the data symbols, each a prefix plus a body.
	// Only the first frame after reset is preceded by the start delay.
	task automatic send_frames(input int k);
		int n;
		n = k * (2 + cur_spf) * (cur_pre + cur_fft);
		if (first_frame) n += cur_delay;
		first_frame = 1'b0;
		send_run(n);
	endtask

	// Stops h samples into the body of the first data symbol, changes the FFT size
	// there and finishes the frame. A body already past the new size ends on the
	// next sample, since the body compare is greater-or-equal.
	task automatic refit_mid_symbol(input int h, input int f_new);
		int n;
		n = 2 * (cur_pre + cur_fft) + cur_pre + h;
		if (first_frame) n += cur_delay;
		first_frame = 1'b0;
		send_run(n);
		settle();
		put_reg(REG_FFT_SIZE, CFG_DATA_W'(f_new) | (CFG_DATA_W'($urandom) << FFT_W));
		cfg_we <= 1'b0;
		cur_fft = f_new;
		settings++;
		n = ((f_new > h) ? f_new - h : 1) + (cur_spf - 1) * (cur_pre + f_new);
		send_run(n);
	endtask

	// Result side: a random stall before each item, in stretches with and without
	// stalls. Once, in the middle of a long run of passed samples, it holds off for
	// a long stretch while the sender keeps offering, so the gate fills up and drops
	// s_axis_tready.
	initial begin : result_sink
		int  stall;
		int  run_left;
		int  taken;
		bit  idling;
		m_axis_tready = 1'b0;
		run_left = 0;
		taken = 0;
		idling = 1'b1;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (run_left == 0) begin
				idling = ($urandom_range(0, 3) != 0);
				run_left = $urandom_range(10, 80);
			end
			run_left--;
			stall = idling ? $urandom_range(0, 9) : 0;
			if (taken == 100) stall = 300;
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			taken++;
		end
	end

	initial begin : stimulus
		int base;
		int f;
		int p;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_FFT_SIZE;
		cfg_wdata = '0;
		arst_n = 1'b0;
		sent = 0;
		settings = 0;
		tx_run_left = 0;
		tx_idling = 1'b1;
		first_frame = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First frame after reset: a start delay, tiny symbols, two per frame.
		// The prefix is kept above one here, since a prefix of one right after
		// the start delay would only match again once the counter wraps.
		apply_cfg(4, 3, 7, 2);
		send_frames(1);
		settle();

		// FFT size grown in the middle of a symbol, then shrunk below the
		// samples already seen in the body.
		refit_mid_symbol(2, 9);
		settle();
		refit_mid_symbol(5, 2);
		settle();

		// Prefix of one on later frames, and a zero start delay written.
		apply_cfg(3, 1, 0, 3);
		send_frames(2);
		settle();

		// One long symbol: its passed samples are the 53rd to the 212th result,
		// so the long hold-off of the result side falls inside it.
		apply_cfg(160, 2, 0, 1);
		send_frames(1);
		settle();

		// Random settings, mostly small, each run for whole frames; now and then
		// the FFT size is changed inside a symbol.
		base = sent;
		while (sent - base < 450) begin
			f = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 24);
			p = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 24) : $urandom_range(1, 12);
			apply_cfg(f, p, $urandom_range(0, 1048575), $urandom_range(1, 5));
			if (cur_fft >= 2 && $urandom_range(0, 3) == 0) begin
				refit_mid_symbol($urandom_range(1, cur_fft - 1), $urandom_range(1, 30));
				settle();
			end
			send_frames($urandom_range(1, 2));
			settle();
		end

		$display("tb: %0d samples sent over %0d register settings, %0d passed samples checked",
			sent, settings, checked);
		$display("tb: %0d mismatches, %0d samples still expected", fail_count, pending);
		if (fail_count == 0 && pending == 0) begin
			$display("tb: PASS");
		end else begin
			$display("tb: FAIL");
		end
		$finish;
	end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ofdmpg_pkg.sv
rtl/ofdmpg_seq.sv
rtl/ofdm_frame_prefix_gate.sv
rtl/ofdmpg_chk.sv
bench/ofdm_frame_prefix_gate_chk.sv
bench/tb.sv
